/* rtl/pfc_pkg.sv */
// pfc_pkg: shared types and constants for the playfair digraph cipher
// no dependencies
`default_nettype none
package pfc_pkg;
   localparam logic [2:0] MODE_KEY = 3'd0;
   localparam logic [2:0] MODE_FIN = 3'd1;
   localparam logic [2:0] MODE_ENC = 3'd2;
   localparam logic [2:0] MODE_DEC = 3'd3;
   localparam logic [2:0] MODE_END = 3'd4;
   localparam logic [4:0] IDX_I = 5'd8;
   localparam logic [4:0] IDX_J = 5'd9;
   localparam logic [4:0] IDX_X = 5'd23;
   localparam int GRID_CELLS = 25;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_PAIR, ST_OUT0, ST_OUT1, ST_OUTE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture request item
      logic       key_place;  // place folded letter
      logic       fill_step;  // place fill counter letter
      logic       feed;       // feed letter (x when feed_x) to pair stream
      logic       feed_x;
      logic       feed_dec;
      logic       mark_last;  // encrypt bookkeeping
      logic       clr_last;
      logic       clr_held;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] mode;
      logic       is_letter;
      logic       dup;        // same as last kept letter
      logic       held_valid;
      logic       held_dec;
      logic       fill_done;
   } stat_type;

   function automatic logic [5:0] fold(input logic [7:0] s);
      logic [7:0] u;
      logic [4:0] i;
      u = (s >= 8'h61 && s <= 8'h7a) ? s - 8'd32 : s;
      if (u < 8'h41 || u > 8'h5a) return 6'b100000;
      i = 5'(u - 8'h41);
      if (i == IDX_J) i = IDX_I;
      return {1'b0, i};
   endfunction
endpackage
`default_nettype wire

/* rtl/playfair_digraph_cipher.sv */
// playfair_digraph_cipher: top level joining controller and datapath
// depends on pfc_pkg, pfc_control, pfc_datapath
`default_nettype none
// One item is processed at a time. A cipher item that completes a pair is followed by
// its two results, and an encrypt item with x insertion feeds the x before the letter.
// A key finish walks all 26 letters one per cycle through the single grid write port.
// Results come from a two-entry result register read out one per cycle while
// rsp_ready is high.
module playfair_digraph_cipher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_mode,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_out_letter,
   output logic            rsp_end_flag
);
   import pfc_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [1:0] out_sel;
   logic [6:0] out0, out1;

   pfc_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd, .out_sel
   );

   pfc_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_mode, .req_symbol, .out0, .out1
   );

   always_comb begin
      case (out_sel)
         2'd0: rsp_out_letter = out0;
         2'd1: rsp_out_letter = out1;
         default: rsp_out_letter = 7'd0;
      endcase
      rsp_end_flag = out_sel == 2'd2;
   end
endmodule
`default_nettype wire

/* rtl/pfc_datapath.sv */
// pfc_datapath: grid, letter positions, pair stream and result registers
// depends on pfc_pkg
`default_nettype none
module pfc_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pfc_pkg::cmd_type cmd,
   output pfc_pkg::stat_type    stat,
   input  wire logic [2:0]      req_mode,
   input  wire logic [7:0]      req_symbol,
   output logic [6:0]           out0,
   output logic [6:0]           out1
);
   import pfc_pkg::*;

   logic [4:0] grid_ff [GRID_CELLS];
   logic [4:0] place_ff [26];
   logic [25:0] used_ff;
   logic [4:0] fill_count_ff;
   logic [4:0] fill_idx_ff;
   logic [2:0] mode_ff;
   logic [5:0] sym_ff;
   logic [4:0] held_ff, last_ff;
   logic held_valid_ff, held_dec_ff, last_valid_ff;
   logic [6:0] out0_ff, out1_ff;

   logic [4:0] place_idx, feed_idx;
   logic do_place;
   logic [4:0] p1, p2;
   logic [2:0] r1, c1, r2, c2, ra, ca, rb, cb;
   logic [4:0] cell_a, cell_b;

   always_comb begin
      place_idx = cmd.fill_step ? fill_idx_ff : sym_ff[4:0];
      do_place = (cmd.key_place || (cmd.fill_step && fill_idx_ff != IDX_J))
                 && fill_count_ff < 5'(GRID_CELLS) && !used_ff[place_idx];
      feed_idx = cmd.feed_x ? IDX_X : sym_ff[4:0];
   end

   function automatic logic [2:0] rowof(input logic [4:0] p);
      return (p >= 5'd20) ? 3'd4 : (p >= 5'd15) ? 3'd3 : (p >= 5'd10) ? 3'd2 :
             (p >= 5'd5) ? 3'd1 : 3'd0;
   endfunction

   function automatic logic [2:0] stp(input logic [2:0] v, input logic dec);
      if (dec) return (v == 3'd0) ? 3'd4 : v - 3'd1;
      return (v == 3'd4) ? 3'd0 : v + 3'd1;
   endfunction

   always_comb begin
      p1 = place_ff[held_ff];
      p2 = place_ff[feed_idx];
      r1 = rowof(p1); c1 = 3'(p1 - 5'({r1, 2'b0} + {2'b0, r1}));
      r2 = rowof(p2); c2 = 3'(p2 - 5'({r2, 2'b0} + {2'b0, r2}));
      if (r1 == r2) begin
         ra = r1; ca = stp(c1, cmd.feed_dec); rb = r2; cb = stp(c2, cmd.feed_dec);
      end else if (c1 == c2) begin
         ra = stp(r1, cmd.feed_dec); ca = c1; rb = stp(r2, cmd.feed_dec); cb = c2;
      end else begin
         ra = r1; ca = c2; rb = r2; cb = c1;
      end
      cell_a = 5'({ra, 2'b0} + {2'b0, ra} + {2'b0, ca});
      cell_b = 5'({rb, 2'b0} + {2'b0, rb} + {2'b0, cb});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRID_CELLS; i++) grid_ff[i] <= '0;
         for (int i = 0; i < 26; i++) place_ff[i] <= '0;
         used_ff <= '0;
         fill_count_ff <= '0;
         fill_idx_ff <= '0;
         held_valid_ff <= 1'b0;
         held_dec_ff <= 1'b0;
         held_ff <= '0;
         last_ff <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) fill_idx_ff <= '0;
         else if (cmd.fill_step) fill_idx_ff <= fill_idx_ff + 5'd1;
         if (do_place) begin
            grid_ff[fill_count_ff] <= place_idx;
            place_ff[place_idx] <= fill_count_ff;
            used_ff[place_idx] <= 1'b1;
            fill_count_ff <= fill_count_ff + 5'd1;
         end
         if (cmd.feed) begin
            if (!held_valid_ff) begin
               held_ff <= feed_idx;
               held_valid_ff <= 1'b1;
               held_dec_ff <= cmd.feed_dec;
            end else begin
               held_valid_ff <= 1'b0;
            end
         end
         if (cmd.clr_held) held_valid_ff <= 1'b0;
         if (cmd.mark_last) begin
            last_ff <= sym_ff[4:0];
            last_valid_ff <= 1'b1;
         end
         if (cmd.clr_last) last_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         sym_ff <= fold(req_symbol);
      end
      if (cmd.feed && held_valid_ff) begin
         out0_ff <= 7'h41 + {2'b0, grid_ff[cell_a]};
         out1_ff <= 7'h41 + {2'b0, grid_ff[cell_b]};
      end
   end

   assign stat.mode = mode_ff;
   assign stat.is_letter = !sym_ff[5];
   assign stat.dup = last_valid_ff && last_ff == sym_ff[4:0];
   assign stat.held_valid = held_valid_ff;
   assign stat.held_dec = held_dec_ff;
   // fill walks letters a through z
   assign stat.fill_done = fill_idx_ff == 5'd26;
   assign out0 = out0_ff;
   assign out1 = out1_ff;
endmodule
`default_nettype wire

/* rtl/pfc_control.sv */
// pfc_control: sequencer for one item at a time and result delivery
// depends on pfc_pkg
`default_nettype none
module pfc_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire pfc_pkg::stat_type stat,
   output pfc_pkg::cmd_type      cmd,
   output logic [1:0]            out_sel   // 0 first, 1 second, 2 end marker
);
   import pfc_pkg::*;

   state_type state_ff, state_in;
   logic second_ff, second_in;   // encrypt item with x inserted, letter still to feed
   logic pend_end_ff, pend_end_in;

   always_comb begin
      state_in = state_ff;
      second_in = second_ff;
      pend_end_in = pend_end_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PAIR;
         ST_FILL: if (stat.fill_done) state_in = ST_IDLE;
         ST_PAIR: begin
            second_in = 1'b0;
            pend_end_in = 1'b0;
            state_in = ST_IDLE;
            case (stat.mode)
               MODE_FIN: state_in = ST_FILL;
               MODE_ENC: if (stat.is_letter) begin
                  if (stat.dup && !second_ff) begin
                     second_in = 1'b1;
                     if (stat.held_valid) state_in = ST_OUT0;
                     else state_in = ST_PAIR;
                  end else if (stat.held_valid) state_in = ST_OUT0;
               end
               MODE_DEC: if (stat.is_letter && stat.held_valid) state_in = ST_OUT0;
               MODE_END: begin
                  if (stat.held_valid && !stat.held_dec) begin
                     pend_end_in = 1'b1;
                     state_in = ST_OUT0;
                  end else state_in = ST_OUTE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT0: if (rsp_ready) state_in = ST_OUT1;
         ST_OUT1: if (rsp_ready) begin
            if (pend_end_ff) state_in = ST_OUTE;
            else if (second_ff) state_in = ST_PAIR;
            else state_in = ST_IDLE;
         end
         ST_OUTE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      out_sel = 2'd0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_FILL: cmd.fill_step = !stat.fill_done;
         ST_PAIR: case (stat.mode)
            MODE_KEY: cmd.key_place = stat.is_letter;
            MODE_ENC: if (stat.is_letter) begin
               cmd.feed = 1'b1;
               cmd.feed_x = stat.dup && !second_ff;
               cmd.mark_last = !(stat.dup && !second_ff);
            end
            MODE_DEC: if (stat.is_letter) begin
               cmd.feed = 1'b1;
               cmd.feed_dec = 1'b1;
               cmd.clr_last = 1'b1;
            end
            MODE_END: begin
               cmd.feed = stat.held_valid && !stat.held_dec;
               cmd.feed_x = 1'b1;
               cmd.clr_held = 1'b1;
               cmd.clr_last = 1'b1;
            end
            default: cmd = '0;
         endcase
         ST_OUT0: rsp_valid = 1'b1;
         ST_OUT1: begin
            rsp_valid = 1'b1;
            out_sel = 2'd1;
         end
         ST_OUTE: begin
            rsp_valid = 1'b1;
            out_sel = 2'd2;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         second_ff <= 1'b0;
         pend_end_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         second_ff <= second_in;
         pend_end_ff <= pend_end_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/pfc_checker.sv */
// pfc_checker: port-level assertions for playfair_digraph_cipher
// bound to the top level; no package use
`default_nettype none
module pfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_out_letter,
   input wire logic       rsp_end_flag
);
   // no new item while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready during result");
   // end marker carries zero letter
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_flag |-> rsp_out_letter == 7'd0) else $error("bad end marker");
   // a letter item is an upper-case letter
   a_let: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_flag |-> rsp_out_letter >= 7'h41 && rsp_out_letter <= 7'h5a)
      else $error("bad letter");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_letter))
      else $error("result dropped");
endmodule

bind playfair_digraph_cipher pfc_checker u_chk (.*);
`default_nettype wire
